### hdl/cartesian_to_lat_lon_assert.svh
// ----------------------------------------------------------------------------
// cartesian_to_lat_lon assertion macros
// concurrent checks sampled on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_LAT_LON_ASSERT_SVH
`define CARTESIAN_TO_LAT_LON_ASSERT_SVH

// condition holds at every edge
`define C2LL_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define C2LL_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hdl/c2ll_pkg.sv
// ----------------------------------------------------------------------------
// c2ll_pkg
// shared constants, types and the angle rounding function
// ----------------------------------------------------------------------------
`default_nettype none

package c2ll_pkg;

	localparam int COORD_WIDTH_DEF     = 24;
	localparam int ANGLE_FRAC_BITS_DEF = 21;
	localparam int CORDIC_STEPS_DEF    = 22;

	// coordinates are scaled up by this many bits before the first pass
	localparam int GUARD_BITS = 24;
	// spare integer bits of the datapath above guard and coordinate
	localparam int HEAD_BITS  = 3;

	// angle accumulator: 30 fraction bits, range a little over +-pi
	localparam int ACC_FRAC = 30;
	localparam int ACC_W    = 34;

	localparam longint PI_ACC      = 64'sd3373259426;
	localparam longint HALF_PI_ACC = 64'sd1686629713;

	// 1/K with 31 fraction bits
	localparam int              INV_W     = 31;
	localparam logic [INV_W-1:0] INV_GAIN = 31'd1304065748;

	// floor(atan(2^-i) * 2^30)
	localparam longint ATAN_TAB [32] = '{
		64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
		64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
		64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
		64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767,
		64'sd16383,     64'sd8191,      64'sd4095,      64'sd2047,
		64'sd1023,      64'sd511,       64'sd255,       64'sd127,
		64'sd63,        64'sd31,        64'sd15,        64'sd7,
		64'sd3,         64'sd1,         64'sd0,         64'sd0
	};

	typedef struct packed {
		logic valid;
		logic run;
	} c2ll_ctl_t;

	// round to nearest (ties up) by dropping shift bits, then clamp to +-limit
	function automatic logic signed [ACC_W-1:0] c2ll_round(
		input logic signed [ACC_W-1:0] acc,
		input int                      shift,
		input longint                  lim_acc
	);
		logic signed [ACC_W:0] sum;
		logic signed [ACC_W:0] q;
		logic signed [ACC_W:0] lim;
		sum = $signed({acc[ACC_W-1], acc}) +
			$signed((ACC_W+1)'(longint'(1) <<< (shift - 1)));
		q   = sum >>> shift;
		lim = (ACC_W+1)'((lim_acc + (longint'(1) <<< (shift - 1))) >>> shift);
		if (q > lim) begin
			q = lim;
		end else if (q < -lim) begin
			q = -lim;
		end
		return q[ACC_W-1:0];
	endfunction

endpackage

`default_nettype wire

### hdl/c2ll_point_if.sv
// ----------------------------------------------------------------------------
// c2ll_point_if
// valid/ready channel carrying one cartesian point
// ----------------------------------------------------------------------------
`default_nettype none

interface c2ll_point_if
	import c2ll_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;

	modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
	modport sink (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

`default_nettype wire

### hdl/c2ll_angle_if.sv
// ----------------------------------------------------------------------------
// c2ll_angle_if
// valid/ready channel carrying latitude and longitude in radians
// ----------------------------------------------------------------------------
`default_nettype none

interface c2ll_angle_if
	import c2ll_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic signed [ANGLE_FRAC_BITS+1:0] latitude;
	logic signed [ANGLE_FRAC_BITS+2:0] longitude;

	modport source (output valid, output latitude, output longitude, input ready);
	modport sink (input valid, input latitude, input longitude, output ready);
endinterface

`default_nettype wire

### hdl/c2ll_cordic.sv
// ----------------------------------------------------------------------------
// c2ll_cordic
// pipelined vectoring cordic, one register stage per iteration
// ----------------------------------------------------------------------------
`default_nettype none

module c2ll_cordic
	import c2ll_pkg::*;
#(
	parameter int W      = COORD_WIDTH_DEF + GUARD_BITS + HEAD_BITS,
	parameter int STEPS  = CORDIC_STEPS_DEF,
	parameter int SIDE_W = COORD_WIDTH_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     en,
	input  c2ll_ctl_t               ctl_in,
	input  wire signed [W-1:0]      x_in,
	input  wire signed [W-1:0]      y_in,
	input  wire signed [ACC_W-1:0]  acc_in,
	input  wire [SIDE_W-1:0]        side_in,
	output c2ll_ctl_t               ctl_out,
	output logic signed [W-1:0]     x_out,
	output logic signed [ACC_W-1:0] acc_out,
	output logic [SIDE_W-1:0]       side_out
);

	c2ll_ctl_t               ctl_s  [1:STEPS];
	logic signed [W-1:0]     x_s    [1:STEPS];
	logic signed [W-1:0]     y_s    [1:STEPS];
	logic signed [ACC_W-1:0] acc_s  [1:STEPS];
	logic [SIDE_W-1:0]       side_s [1:STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [ACC_W-1:0] ANGLE = ACC_W'(ATAN_TAB[i]);

		c2ll_ctl_t               ctl_i;
		logic signed [W-1:0]     x_i;
		logic signed [W-1:0]     y_i;
		logic signed [ACC_W-1:0] acc_i;
		logic [SIDE_W-1:0]       side_i;
		logic signed [W-1:0]     dx;
		logic signed [W-1:0]     dy;

		if (i == 0) begin : g_first
			assign ctl_i  = ctl_in;
			assign x_i    = x_in;
			assign y_i    = y_in;
			assign acc_i  = acc_in;
			assign side_i = side_in;
		end else begin : g_next
			assign ctl_i  = ctl_s[i];
			assign x_i    = x_s[i];
			assign y_i    = y_s[i];
			assign acc_i  = acc_s[i];
			assign side_i = side_s[i];
		end

		assign dx = y_i >>> i;
		assign dy = x_i >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_i;
				if (!ctl_i.run) begin
					x_s[i+1]   <= x_i;
					y_s[i+1]   <= y_i;
					acc_s[i+1] <= acc_i;
				end else if (y_i[W-1]) begin
					x_s[i+1]   <= x_i - dx;
					y_s[i+1]   <= y_i + dy;
					acc_s[i+1] <= acc_i - ANGLE;
				end else begin
					x_s[i+1]   <= x_i + dx;
					y_s[i+1]   <= y_i - dy;
					acc_s[i+1] <= acc_i + ANGLE;
				end
			end
		end
	end

	assign ctl_out  = ctl_s[STEPS];
	assign x_out    = x_s[STEPS];
	assign acc_out  = acc_s[STEPS];
	assign side_out = side_s[STEPS];

endmodule

`default_nettype wire

### hdl/c2ll_radius.sv
// ----------------------------------------------------------------------------
// c2ll_radius
// gain correction of the planar radius, longitude rounding and latitude setup
// ----------------------------------------------------------------------------
`default_nettype none

module c2ll_radius
	import c2ll_pkg::*;
#(
	parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int W               = COORD_WIDTH_DEF + GUARD_BITS + HEAD_BITS
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           en,
	input  c2ll_ctl_t                     ctl_in,
	input  wire signed [W-1:0]            x_in,
	input  wire signed [ACC_W-1:0]        acc_in,
	input  wire signed [COORD_WIDTH-1:0]  z_in,
	output c2ll_ctl_t                     ctl_out,
	output logic signed [W-1:0]           r_out,
	output logic signed [W-1:0]           z_out,
	output logic signed [ACC_W-1:0]       acc_out,
	output logic [ANGLE_FRAC_BITS+2:0]    lon_out
);

	localparam int LON_W = ANGLE_FRAC_BITS + 3;
	localparam int SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int HI_W  = W - INV_W;
	localparam logic signed [ACC_W-1:0] HALF_PI_V = ACC_W'(HALF_PI_ACC);

	// stage 1: two partial products of the 1/K correction
	logic [W-1:0]         ur;
	logic [HI_W-1:0]      hi;
	logic [INV_W-1:0]     lo;
	logic [W-1:0]         hi_prod;
	logic [2*INV_W-1:0]   lo_prod;

	c2ll_ctl_t                  ctl_s1;
	logic [W-1:0]               hi_p_s1;
	logic [INV_W-1:0]           lo_p_s1;
	logic signed [W-1:0]        x_s1;
	logic [LON_W-1:0]           lon_s1;
	logic signed [COORD_WIDTH-1:0] z_s1;

	assign ur      = x_in[W-1] ? '0 : x_in;
	assign hi      = ur[W-1:INV_W];
	assign lo      = ur[INV_W-1:0];
	assign hi_prod = W'(hi) * W'(INV_GAIN);
	assign lo_prod = (2*INV_W)'(lo) * (2*INV_W)'(INV_GAIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_p_s1 <= hi_prod;
			lo_p_s1 <= lo_prod[2*INV_W-1:INV_W];
			x_s1    <= x_in;
			lon_s1  <= LON_W'(c2ll_round(acc_in, SHIFT, PI_ACC));
			z_s1    <= z_in;
		end
	end

	// stage 2: radius sum and setup of the latitude pass
	logic signed [W-1:0] r_sum;
	logic signed [W-1:0] r_sel;
	logic signed [W-1:0] z_ext;
	logic                z_zero;
	logic                r_zero;

	assign r_sum  = $signed(hi_p_s1 + W'(lo_p_s1));
	assign r_sel  = ctl_s1.run ? r_sum : x_s1;
	assign z_ext  = $signed({{(W-COORD_WIDTH-GUARD_BITS){z_s1[COORD_WIDTH-1]}},
		z_s1, {GUARD_BITS{1'b0}}});
	assign z_zero = (z_s1 == '0);
	assign r_zero = (r_sel == '0);

	c2ll_ctl_t                ctl_s2;
	logic signed [W-1:0]      r_s2;
	logic signed [W-1:0]      z_s2;
	logic signed [ACC_W-1:0]  acc_s2;
	logic [LON_W-1:0]         lon_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid <= ctl_s1.valid;
			ctl_s2.run   <= !z_zero && !r_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2   <= r_sel;
			z_s2   <= z_ext;
			lon_s2 <= lon_s1;
			if (z_zero || !r_zero) begin
				acc_s2 <= '0;
			end else if (z_s1[COORD_WIDTH-1]) begin
				acc_s2 <= -HALF_PI_V;
			end else begin
				acc_s2 <= HALF_PI_V;
			end
		end
	end

	assign ctl_out = ctl_s2;
	assign r_out   = r_s2;
	assign z_out   = z_s2;
	assign acc_out = acc_s2;
	assign lon_out = lon_s2;

endmodule

`default_nettype wire

### hdl/cartesian_to_lat_lon.sv
// ----------------------------------------------------------------------------
// cartesian_to_lat_lon
// cartesian point to latitude and longitude through two pipelined cordic passes
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  point     in    valid / ready   coord_x, coord_y, coord_z
//  angles    out   valid / ready   latitude, longitude
//
//  one transaction per cycle while no result waits in the skid register; the pipeline
//  has one register stage per cordic iteration in each of the two passes
//  arst_n clears every valid bit, those of the output and skid registers included
//  the whole pipeline advances together; a stalled output parks one result in
//  a skid register and the pipeline holds until it drains
// ----------------------------------------------------------------------------
`default_nettype none

`include "cartesian_to_lat_lon_assert.svh"

module cartesian_to_lat_lon
	import c2ll_pkg::*;
#(
	parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
	input wire           clk,
	input wire           arst_n,
	c2ll_point_if.sink   point,
	c2ll_angle_if.source angles
);

	localparam int W     = COORD_WIDTH + GUARD_BITS + HEAD_BITS;
	localparam int LAT_W = ANGLE_FRAC_BITS + 2;
	localparam int LON_W = ANGLE_FRAC_BITS + 3;
	localparam int SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [ACC_W-1:0] PI_V      = ACC_W'(PI_ACC);
	localparam logic signed [ACC_W-1:0] HALF_PI_V = ACC_W'(HALF_PI_ACC);
	localparam logic signed [LAT_W-1:0] LAT_LIM   =
		LAT_W'(c2ll_round(HALF_PI_V, SHIFT, HALF_PI_ACC));
	localparam logic signed [LON_W-1:0] LON_LIM   =
		LON_W'(c2ll_round(PI_V, SHIFT, PI_ACC));

	logic en;
	logic skid_valid_q;

	assign en          = !skid_valid_q;
	assign point.ready = en;

	// input stage: scale, axis cases and left half plane pre-rotation
	logic signed [W-1:0] xe;
	logic signed [W-1:0] ye;
	logic                x_neg;
	logic                y_neg;
	logic                x_zero;
	logic                y_zero;
	logic signed [W-1:0]     x_pre;
	logic signed [W-1:0]     y_pre;
	logic signed [ACC_W-1:0] acc_pre;
	logic                    run_pre;

	assign xe = $signed({{HEAD_BITS{point.coord_x[COORD_WIDTH-1]}}, point.coord_x,
		{GUARD_BITS{1'b0}}});
	assign ye = $signed({{HEAD_BITS{point.coord_y[COORD_WIDTH-1]}}, point.coord_y,
		{GUARD_BITS{1'b0}}});
	assign x_neg  = point.coord_x[COORD_WIDTH-1];
	assign y_neg  = point.coord_y[COORD_WIDTH-1];
	assign x_zero = (point.coord_x == '0);
	assign y_zero = (point.coord_y == '0);

	always_comb begin
		x_pre   = xe;
		y_pre   = ye;
		acc_pre = '0;
		run_pre = 1'b1;
		if (y_zero) begin
			run_pre = 1'b0;
			y_pre   = '0;
			if (x_neg) begin
				x_pre   = -xe;
				acc_pre = PI_V;
			end
		end else if (x_zero) begin
			run_pre = 1'b0;
			if (y_neg) begin
				x_pre   = -ye;
				acc_pre = -HALF_PI_V;
			end else begin
				x_pre   = ye;
				acc_pre = HALF_PI_V;
			end
		end else if (x_neg) begin
			if (y_neg) begin
				x_pre   = -ye;
				y_pre   = xe;
				acc_pre = -HALF_PI_V;
			end else begin
				x_pre   = ye;
				y_pre   = -xe;
				acc_pre = HALF_PI_V;
			end
		end
	end

	c2ll_ctl_t                     ctl_s1;
	logic signed [W-1:0]           x_s1;
	logic signed [W-1:0]           y_s1;
	logic signed [ACC_W-1:0]       acc_s1;
	logic signed [COORD_WIDTH-1:0] z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= point.valid;
			ctl_s1.run   <= run_pre;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_pre;
			y_s1   <= y_pre;
			acc_s1 <= acc_pre;
			z_s1   <= point.coord_z;
		end
	end

	// longitude pass
	c2ll_ctl_t                ctl_lon;
	logic signed [W-1:0]      x_lon;
	logic signed [ACC_W-1:0]  acc_lon;
	logic [COORD_WIDTH-1:0]   z_lon;

	c2ll_cordic #(
		.W      (W),
		.STEPS  (CORDIC_STEPS),
		.SIDE_W (COORD_WIDTH)
	) u_lon_pass (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_in   (ctl_s1),
		.x_in     (x_s1),
		.y_in     (y_s1),
		.acc_in   (acc_s1),
		.side_in  (z_s1),
		.ctl_out  (ctl_lon),
		.x_out    (x_lon),
		.acc_out  (acc_lon),
		.side_out (z_lon)
	);

	// radius correction
	c2ll_ctl_t                ctl_rad;
	logic signed [W-1:0]      r_rad;
	logic signed [W-1:0]      z_rad;
	logic signed [ACC_W-1:0]  acc_rad;
	logic [LON_W-1:0]         lon_rad;

	c2ll_radius #(
		.COORD_WIDTH     (COORD_WIDTH),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.W               (W)
	) u_radius (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_lon),
		.x_in    (x_lon),
		.acc_in  (acc_lon),
		.z_in    ($signed(z_lon)),
		.ctl_out (ctl_rad),
		.r_out   (r_rad),
		.z_out   (z_rad),
		.acc_out (acc_rad),
		.lon_out (lon_rad)
	);

	// latitude pass
	c2ll_ctl_t                ctl_lat;
	logic signed [W-1:0]      x_lat;
	logic signed [ACC_W-1:0]  acc_lat;
	logic [LON_W-1:0]         lon_lat;

	c2ll_cordic #(
		.W      (W),
		.STEPS  (CORDIC_STEPS),
		.SIDE_W (LON_W)
	) u_lat_pass (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_in   (ctl_rad),
		.x_in     (r_rad),
		.y_in     (z_rad),
		.acc_in   (acc_rad),
		.side_in  (lon_rad),
		.ctl_out  (ctl_lat),
		.x_out    (x_lat),
		.acc_out  (acc_lat),
		.side_out (lon_lat)
	);

	// output register with skid
	logic [LAT_W-1:0] lat_new;
	logic             take;
	logic             fire;
	logic             out_valid_q;
	logic [LAT_W-1:0] out_lat_q;
	logic [LON_W-1:0] out_lon_q;
	logic [LAT_W-1:0] skid_lat_q;
	logic [LON_W-1:0] skid_lon_q;

	assign lat_new = LAT_W'(c2ll_round(acc_lat, SHIFT, HALF_PI_ACC));
	assign take    = en && ctl_lat.valid && (x_lat == x_lat);
	assign fire    = out_valid_q && angles.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || fire) begin
			out_valid_q  <= skid_valid_q || take;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || fire) begin
			if (skid_valid_q) begin
				out_lat_q <= skid_lat_q;
				out_lon_q <= skid_lon_q;
			end else begin
				out_lat_q <= lat_new;
				out_lon_q <= lon_lat;
			end
		end else if (take) begin
			skid_lat_q <= lat_new;
			skid_lon_q <= lon_lat;
		end
	end

	assign angles.valid     = out_valid_q;
	assign angles.latitude  = $signed(out_lat_q);
	assign angles.longitude = $signed(out_lon_q);

	`C2LL_ASSERT_IMPLY(a_skid_needs_out, skid_valid_q, out_valid_q, "skid full with empty output")
	`C2LL_ASSERT_IMPLY(a_skid_on_stall, $rose(skid_valid_q), $past(out_valid_q && !angles.ready), "skid filled without a stall")
	`C2LL_ASSERT_IMPLY(a_lat_range, angles.valid, ($signed(angles.latitude) <= LAT_LIM) && ($signed(angles.latitude) >= -LAT_LIM), "latitude beyond pi/2")
	`C2LL_ASSERT_IMPLY(a_lon_range, angles.valid, ($signed(angles.longitude) <= LON_LIM) && ($signed(angles.longitude) >= -LON_LIM), "longitude beyond pi")

endmodule

`default_nettype wire
